// ===== rtl/core/path_length_accumulator_core_assert.svh =====
// assertion macros used by the checker file pla_checker.sv
`ifndef PATH_LENGTH_ACCUMULATOR_CORE_ASSERT_SVH
`define PATH_LENGTH_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, idle while reset is held
`define PLA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle while reset is held
`define PLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication that also checks across reset
`define PLA_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pla_pkg.sv =====
package pla_pkg;

    // field and bus widths of the stream ports
    localparam int IN_FIELD_W  = 16;
    localparam int IN_TDATA_W  = 2 * IN_FIELD_W;
    localparam int OUT_TDATA_W = 48;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_MUL   = 5'b00010,
        S_START = 5'b00100,
        S_ROOT  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

endpackage

// ===== rtl/core/pla_sqrt.sv =====
module pla_sqrt #(
    parameter int RAD_W     = 34,
    parameter int FRAC_BITS = 16,
    parameter int ROOT_W    = RAD_W / 2 + FRAC_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int SR_W  = RAD_W + 2 * FRAC_BITS;
    localparam int ITERS = SR_W / 2;
    localparam int REM_W = ROOT_W + 3;
    localparam int CNT_W = $clog2(ITERS);

    logic [SR_W-1:0]   r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W-1:0]  w_rem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_fit;

    // one root bit per cycle: bring down two radicand bits, try 4q+1
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[SR_W-1 -: 2]};
    assign w_trial  = REM_W'({r_root, 2'b01});
    assign w_fit    = (w_rem_sh >= w_trial);

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(ITERS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // radicand shift register, partial remainder and root
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= SR_W'(i_radicand) << (2 * FRAC_BITS);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[ROOT_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== rtl/core/path_length_accumulator_core.sv =====
// first point of a path: no hop to compute
// later points: the hop runs through S_MUL, S_START and S_ROOT, where the
// bit-serial square root resolves one root bit per cycle
// one item at a time; the finished total waits in an output register so the next path can start
// last point: S_EMIT moves the total out once the output register is free
// reset (synchronous, active low) clears the sequencer, the running total and the output valid
module path_length_accumulator_core import pla_pkg::*; #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16,
    parameter int TOTAL_BITS = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // x [15:0], y [31:16]
    input  logic                   i_s_tlast,   // last
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // total_length [47:0]
    output logic                   o_m_tuser    // saturated
);

    localparam int CB     = COORD_BITS;
    localparam int XW     = (CB > IN_FIELD_W) ? CB : IN_FIELD_W;
    localparam int SQ_W   = 2 * CB;
    localparam int RAD_W  = 2 * CB + 2;
    localparam int ROOT_W = CB + 1 + FRAC_BITS;
    localparam int SUM_W  = ((ROOT_W > TOTAL_BITS) ? ROOT_W : TOTAL_BITS) + 1;
    localparam logic [TOTAL_BITS-1:0] TMAX = '1;

    t_state                r_state;
    t_state                n_state;
    logic [CB-1:0]         r_prev_x;
    logic [CB-1:0]         r_prev_y;
    logic                  r_have_prev;
    logic                  r_last;
    logic [CB-1:0]         r_dx;
    logic [CB-1:0]         r_dy;
    logic [SQ_W-1:0]       r_sqx;
    logic [SQ_W-1:0]       r_sqy;
    logic [TOTAL_BITS-1:0] r_total;
    logic                  r_sat;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_total;
    logic                  r_out_sat;

    logic [XW-1:0]         w_x_raw;
    logic [XW-1:0]         w_y_raw;
    logic [CB:0]           w_x;
    logic [CB:0]           w_y;
    logic [CB:0]           w_dxs;
    logic [CB:0]           w_dys;
    logic [CB-1:0]         w_dx;
    logic [CB-1:0]         w_dy;
    logic                  w_s_acc;
    logic                  w_emit;
    logic                  w_start;
    logic                  w_root_done;
    logic [ROOT_W-1:0]     w_root;
    logic [RAD_W-1:0]      w_radicand;
    logic [SUM_W-1:0]      w_sum;

    // coordinates: low COORD_BITS bits, sign-extended one bit for the difference
    assign w_x_raw = XW'(i_s_tdata[IN_FIELD_W-1:0]);
    assign w_y_raw = XW'(i_s_tdata[IN_TDATA_W-1:IN_FIELD_W]);
    assign w_x     = {w_x_raw[CB-1], w_x_raw[CB-1:0]};
    assign w_y     = {w_y_raw[CB-1], w_y_raw[CB-1:0]};

    // absolute differences against the previous point
    assign w_dxs = w_x - {r_prev_x[CB-1], r_prev_x};
    assign w_dys = w_y - {r_prev_y[CB-1], r_prev_y};
    assign w_dx  = w_dxs[CB] ? CB'(-w_dxs) : w_dxs[CB-1:0];
    assign w_dy  = w_dys[CB] ? CB'(-w_dys) : w_dys[CB-1:0];

    // handshakes
    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_emit     = (r_state == S_EMIT) && (!r_out_valid || i_m_tready);
    assign w_start    = (r_state == S_START);

    // squared distance and hop root
    assign w_radicand = RAD_W'(r_sqx) + RAD_W'(r_sqy);

    pla_sqrt #(
        .RAD_W     (RAD_W),
        .FRAC_BITS (FRAC_BITS),
        .ROOT_W    (ROOT_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_radicand (w_radicand),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // saturating accumulate
    assign w_sum = SUM_W'(r_total) + SUM_W'(w_root);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_s_acc) begin
                    if (r_have_prev) begin
                        n_state = S_MUL;
                    end else if (i_s_tlast) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_MUL: begin
                n_state = S_START;
            end
            S_START: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_root_done) begin
                    n_state = r_last ? S_EMIT : S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_emit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and path state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
            r_total     <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_s_acc) begin
                r_have_prev <= 1'b1;
            end
            if ((r_state == S_ROOT) && w_root_done) begin
                if (w_sum > SUM_W'(TMAX)) begin
                    r_total <= TMAX;
                    r_sat   <= 1'b1;
                end else begin
                    r_total <= w_sum[TOTAL_BITS-1:0];
                end
            end
            if (w_emit) begin
                r_have_prev <= 1'b0;
                r_total     <= '0;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_prev_x <= w_x[CB-1:0];
            r_prev_y <= w_y[CB-1:0];
            r_last   <= i_s_tlast;
            r_dx     <= w_dx;
            r_dy     <= w_dy;
        end
        if (r_state == S_MUL) begin
            r_sqx <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_sqy <= SQ_W'(r_dy) * SQ_W'(r_dy);
        end
        if (w_emit) begin
            r_out_total <= OUT_TDATA_W'(r_total);
            r_out_sat   <= r_sat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_total;
    assign o_m_tuser  = r_out_sat;

endmodule

// ===== rtl/core/pla_checker.sv =====
`include "path_length_accumulator_core_assert.svh"

module pla_checker import pla_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   i_s_tlast,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata,
    input logic                   o_m_tuser
);

    // no result is offered right after reset
    `PLA_ASSERT_NEXT_ALWAYS(a_rst_no_valid, !i_rst_n, !o_m_tvalid, "result valid after reset")

    // a stalled result stays offered
    `PLA_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid, "result dropped")

    // a path end always takes the block busy in the cycle after it is taken
    `PLA_ASSERT_NEXT(a_last_busy, i_s_tvalid && o_s_tready && i_s_tlast, !o_s_tready,
        "ready after last item")

    // a saturated total sits at the maximum and is never zero
    `PLA_ASSERT_SAME(a_sat_nonzero, o_m_tvalid && o_m_tuser, o_m_tdata != '0,
        "saturated total is zero")

endmodule

bind path_length_accumulator_core pla_checker u_pla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
